### hw/rtl/isp_pkg.sv
// isp_pkg: shared types, constants and character helpers for the integer
// string parser. No dependencies; imported by the interfaces and all modules.
package isp_pkg;

    localparam int ValueWidth    = 64;
    localparam int CountWidth    = 16;
    localparam int BaseWidth     = 6;
    localparam int CharWidth     = 8;
    localparam int CfgIndexWidth = 1;
    localparam int CfgDataWidth  = 6;

    localparam logic [CfgIndexWidth-1:0] CFG_NUMBER_BASE   = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SIGNED_RESULT = 1'd1;

    localparam logic [BaseWidth-1:0] BaseDetect   = 6'd0;
    localparam logic [BaseWidth-1:0] BaseInvalid  = 6'd1;
    localparam logic [BaseWidth-1:0] BaseOctal    = 6'd8;
    localparam logic [BaseWidth-1:0] BaseDecimal  = 6'd10;
    localparam logic [BaseWidth-1:0] BaseHex      = 6'd16;
    localparam logic [BaseWidth-1:0] BaseMax      = 6'd36;
    localparam logic [BaseWidth-1:0] NotDigit     = 6'd36;
    localparam logic [BaseWidth-1:0] BaseReset    = BaseDecimal;

    localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
    localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
    localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
    localparam logic [CharWidth-1:0] CharZero   = 8'h30;
    localparam logic [CharWidth-1:0] CharLowerX = 8'h78;
    localparam logic [CharWidth-1:0] CharUpperX = 8'h58;

    localparam logic [ValueWidth-1:0] AllOnes   = {ValueWidth{1'b1}};
    localparam logic [ValueWidth-1:0] PosLimit  = {1'b0, {(ValueWidth-1){1'b1}}};
    localparam logic [ValueWidth-1:0] NegLimit  = {1'b1, {(ValueWidth-1){1'b0}}};

    // end-of-string snapshot handed from the parser to the result stage
    typedef struct packed {
        logic [ValueWidth-1:0] accumulator;
        logic                  overflowed;
        logic                  negative;
        logic                  any_digit;
        logic                  signed_result;
        logic [CountWidth-1:0] end_position;
    } isp_snap_t;

    function automatic logic [BaseWidth-1:0] digit_of(input logic [CharWidth-1:0] c);
        logic [BaseWidth-1:0] d;
        d = NotDigit;
        if (c inside {[8'h30:8'h39]})
            d = BaseWidth'(c - 8'h30);
        else if (c inside {[8'h61:8'h7A]})
            d = BaseWidth'(c - 8'h61 + 8'd10);
        else if (c inside {[8'h41:8'h5A]})
            d = BaseWidth'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    function automatic logic is_space(input logic [CharWidth-1:0] c);
        return (c == CharSpace) || (c inside {[8'h09:8'h0D]});
    endfunction

endpackage

### hw/rtl/isp_if.sv
// isp_if: valid/ready stream interfaces for characters in and results out.
// Depends on isp_pkg for field widths.
interface isp_char_if import isp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface isp_result_if import isp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] consumed_count;
    logic                  converted;
    logic                  range_error;

    modport source (output valid, output value, output consumed_count,
                    output converted, output range_error, input ready);
    modport sink   (input valid, input value, input consumed_count,
                    input converted, input range_error, output ready);
endinterface

### hw/rtl/isp_parse.sv
// isp_parse: per-character parse state machine with the shared multiply-add.
// Depends on isp_pkg; snapshot output is registered by the top level.
module isp_parse
    import isp_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [CharWidth-1:0] character,
    input  logic                 last,
    input  logic [BaseWidth-1:0] number_base,
    input  logic                 signed_result,
    output isp_snap_t            snap
);

    localparam logic [2:0] PhSpace  = 3'd0;
    localparam logic [2:0] PhStart  = 3'd1;
    localparam logic [2:0] PhZero   = 3'd2;
    localparam logic [2:0] PhXseen  = 3'd3;
    localparam logic [2:0] PhDigits = 3'd4;
    localparam logic [2:0] PhDone   = 3'd5;

    localparam int ProdWidth = ValueWidth + BaseWidth;
    localparam logic [POSITION_WIDTH-1:0] PosMax = {POSITION_WIDTH{1'b1}};

    logic [2:0]                phase_reg, phase_next;
    logic                      neg_reg, neg_next;
    logic [BaseWidth-1:0]      eb_reg, eb_next;
    logic [ValueWidth-1:0]     acc_reg, acc_next;
    logic                      ovf_reg, ovf_next;
    logic                      any_reg, any_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH:0]   end_reg, end_next;

    logic                 take;
    logic                 begin_subject;
    logic                 base_bad;
    logic [BaseWidth-1:0] use_base;
    logic [BaseWidth-1:0] digit;
    logic [ProdWidth-1:0] prod;

    assign digit    = digit_of(character);
    assign base_bad = (number_base == BaseInvalid) || (number_base > BaseMax);

    always_comb
    begin
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        eb_next       = eb_reg;
        use_base      = eb_reg;
        take          = 1'b0;
        begin_subject = 1'b0;
        case (phase_reg)
            PhSpace:
            begin
                if (is_space(character))
                begin
                    phase_next = PhSpace;
                end
                else if (character == CharPlus || character == CharMinus)
                begin
                    neg_next   = (character == CharMinus);
                    phase_next = PhStart;
                end
                else
                begin
                    begin_subject = 1'b1;
                end
            end
            PhStart:
            begin
                begin_subject = 1'b1;
            end
            PhZero:
            begin
                if (character == CharLowerX || character == CharUpperX)
                begin
                    phase_next = PhXseen;
                end
                else if (digit < eb_reg)
                begin
                    take       = 1'b1;
                    phase_next = PhDigits;
                end
                else
                begin
                    phase_next = PhDone;
                end
            end
            PhXseen:
            begin
                if (digit < BaseHex)
                begin
                    eb_next    = BaseHex;
                    use_base   = BaseHex;
                    take       = 1'b1;
                    phase_next = PhDigits;
                end
                else
                begin
                    phase_next = PhDone;
                end
            end
            PhDigits:
            begin
                if (digit < eb_reg)
                begin
                    take       = 1'b1;
                    phase_next = PhDigits;
                end
                else
                begin
                    phase_next = PhDone;
                end
            end
            default:
            begin
                phase_next = PhDone;
            end
        endcase

        if (begin_subject)
        begin
            if (base_bad)
            begin
                phase_next = PhDone;
            end
            else if (character == CharZero &&
                     (number_base == BaseDetect || number_base == BaseHex))
            begin
                eb_next    = (number_base == BaseDetect) ? BaseOctal : BaseHex;
                use_base   = eb_next;
                take       = 1'b1;
                phase_next = PhZero;
            end
            else
            begin
                eb_next  = (number_base == BaseDetect) ? BaseDecimal : number_base;
                use_base = eb_next;
                if (digit < use_base)
                begin
                    take       = 1'b1;
                    phase_next = PhDigits;
                end
                else
                begin
                    phase_next = PhDone;
                end
            end
        end
    end

    // acc * base + digit; anything above bit 63 means overflow
    assign prod = ProdWidth'(acc_reg) * ProdWidth'(use_base) + ProdWidth'(digit);

    always_comb
    begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        any_next = any_reg;
        end_next = end_reg;
        if (take)
        begin
            any_next = 1'b1;
            end_next = {1'b0, pos_reg} + 1'b1;
            if (!ovf_reg)
            begin
                if (|prod[ProdWidth-1:ValueWidth])
                    ovf_next = 1'b1;
                else
                    acc_next = prod[ValueWidth-1:0];
            end
        end
        pos_next = (pos_reg < PosMax) ? pos_reg + 1'b1 : pos_reg;
    end

    always_comb
    begin
        snap.accumulator   = acc_next;
        snap.overflowed    = ovf_next;
        snap.negative      = neg_next;
        snap.any_digit     = any_next;
        snap.signed_result = signed_result;
        snap.end_position  = CountWidth'(end_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PhSpace;
            neg_reg   <= 1'b0;
            eb_reg    <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            any_reg   <= 1'b0;
            pos_reg   <= '0;
            end_reg   <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg <= PhSpace;
                neg_reg   <= 1'b0;
                eb_reg    <= '0;
                acc_reg   <= '0;
                ovf_reg   <= 1'b0;
                any_reg   <= 1'b0;
                pos_reg   <= '0;
                end_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                eb_reg    <= eb_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                any_reg   <= any_next;
                pos_reg   <= pos_next;
                end_reg   <= end_next;
            end
        end
    end

    a_ovf_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> any_reg)
        else $error("overflow flagged without any digit");

    a_acc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !(step && last)) |=> $stable(acc_reg))
        else $error("accumulator moved after overflow");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (phase_reg == PhSpace && !any_reg && pos_reg == '0))
        else $error("parser not rearmed after end of string");

endmodule

### hw/rtl/integer_string_parser_unit.sv
// A string's result passes through the snapshot register into the result register.
// Throughput: one character per cycle; input register, parse/multiply-add stage
// and result register advance together whenever the result register is empty or being read.
// Reset (rst_n, async, active low): parser rearmed, pipeline empty,
// number_base = 10, signed_result = 1.
module integer_string_parser_unit
    import isp_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    isp_char_if.sink                 char_stream,
    isp_result_if.source             result_stream,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic [BaseWidth-1:0] number_base_reg;
    logic                 signed_result_reg;

    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_last_reg;

    logic      snap_valid_reg;
    isp_snap_t snap_reg;
    isp_snap_t snap_next;

    logic                  out_valid_reg;
    logic [ValueWidth-1:0] out_value_reg, out_value_next;
    logic [CountWidth-1:0] out_count_reg, out_count_next;
    logic                  out_conv_reg, out_conv_next;
    logic                  out_range_reg, out_range_next;

    logic                  advance;
    logic                  step;
    logic [ValueWidth-1:0] mag;
    logic [ValueWidth-1:0] mag_neg;
    logic                  sat;

    assign advance           = !out_valid_reg || result_stream.ready;
    assign char_stream.ready = !in_valid_reg || advance;
    assign step              = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg   <= BaseReset;
            signed_result_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUMBER_BASE:   number_base_reg   <= cfg_data[BaseWidth-1:0];
                CFG_SIGNED_RESULT: signed_result_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    isp_parse #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .character     (in_char_reg),
        .last          (in_last_reg),
        .number_base   (number_base_reg),
        .signed_result (signed_result_reg),
        .snap          (snap_next)
    );

    // final value: saturation, negation, no-conversion case
    always_comb
    begin
        mag     = snap_reg.overflowed ? AllOnes : snap_reg.accumulator;
        mag_neg = '0 - mag;
        sat     = snap_reg.overflowed ||
                  (!snap_reg.negative && mag[ValueWidth-1]) ||
                  (snap_reg.negative && mag[ValueWidth-1] && |mag[ValueWidth-2:0]);
        out_value_next = '0;
        out_range_next = 1'b0;
        if (snap_reg.any_digit)
        begin
            if (snap_reg.signed_result)
            begin
                if (sat)
                begin
                    out_range_next = 1'b1;
                    out_value_next = snap_reg.negative ? NegLimit : PosLimit;
                end
                else
                begin
                    out_value_next = snap_reg.negative ? mag_neg : mag;
                end
            end
            else if (snap_reg.overflowed)
            begin
                out_range_next = 1'b1;
                out_value_next = AllOnes;
            end
            else
            begin
                out_value_next = snap_reg.negative ? mag_neg : mag;
            end
        end
        out_count_next = snap_reg.any_digit ? snap_reg.end_position : '0;
        out_conv_next  = snap_reg.any_digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (char_stream.ready)
                in_valid_reg <= char_stream.valid;
            if (advance)
            begin
                snap_valid_reg <= in_valid_reg && in_last_reg;
                out_valid_reg  <= snap_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_stream.valid && char_stream.ready)
        begin
            in_char_reg <= char_stream.character;
            in_last_reg <= char_stream.last;
        end
        if (step && in_last_reg)
            snap_reg <= snap_next;
        if (advance && snap_valid_reg)
        begin
            out_value_reg <= out_value_next;
            out_count_reg <= out_count_next;
            out_conv_reg  <= out_conv_next;
            out_range_reg <= out_range_next;
        end
    end

    assign result_stream.valid          = out_valid_reg;
    assign result_stream.value          = out_value_reg;
    assign result_stream.consumed_count = out_count_reg;
    assign result_stream.converted      = out_conv_reg;
    assign result_stream.range_error    = out_range_reg;

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_conv_reg) |->
            (out_value_reg == '0 && out_count_reg == '0 && !out_range_reg))
        else $error("unconverted result carries nonzero fields");

    a_range_needs_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_range_reg) |-> out_conv_reg)
        else $error("range error without conversion");

    a_out_from_snap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(snap_valid_reg))
        else $error("result transaction without end-of-string snapshot");

endmodule
